@@ rtl/h27sf_pkg.sv @@
`timescale 1ns / 1ps

package h27sf_pkg;

   localparam int NODE_COUNT = 27;
   localparam int NODE_W = 5;
   localparam int COORD_W = 18;
   localparam int SHAPE_W = 18;
   localparam int DERIV_W = 19;
   localparam int AXES = 3;
   localparam int LANE_STAGES = 5;
   localparam logic [NODE_W-1:0] LAST_NODE = 5'd26;

   // Basis pick per axis for each node: 0 = x(x-1)/2, 1 = 1-x^2, 2 = x(x+1)/2
   localparam logic [1:0] NODE_SEL [NODE_COUNT][AXES] = '{
      '{2'd0, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd0}, '{2'd2, 2'd2, 2'd0},
      '{2'd0, 2'd2, 2'd0}, '{2'd0, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd2},
      '{2'd2, 2'd2, 2'd2}, '{2'd0, 2'd2, 2'd2}, '{2'd1, 2'd0, 2'd0},
      '{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0},
      '{2'd2, 2'd0, 2'd1}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd2, 2'd1},
      '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2}, '{2'd0, 2'd1, 2'd2},
      '{2'd2, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd2}, '{2'd1, 2'd1, 2'd0},
      '{2'd1, 2'd0, 2'd1}, '{2'd0, 2'd1, 2'd1}, '{2'd2, 2'd1, 2'd1},
      '{2'd1, 2'd2, 2'd1}, '{2'd1, 2'd1, 2'd2}, '{2'd1, 2'd1, 2'd1}
   };

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              last;
   } meta_type;

endpackage

@@ rtl/hex27_shape_function_eval_core.sv @@
`timescale 1ns / 1ps

// Shape functions of the 27-node triquadratic brick at one reference point.
// Request channel: one word is a point (csi, eta, zeta), signed with
// FRAC_BITS fraction bits; each coordinate is clamped to [-1, 1].
// Response channel: 27 words per point, node 0 to 26 in element order,
// each with the shape value and its three partial derivatives, rounded to
// nearest; rsp_last_node marks node 26.
// Throughput: one response word per cycle while rsp_stall is low; the next
// point is taken in while the current one is still being swept, so runs
// follow each other with no gap.
// Pipeline from request accept to the first response word: capture, basis
// build, node select, five multiply/round stages.
// Stall: rsp_stall on a valid word freezes the whole node pipeline and the
// node counter; nothing is dropped or repeated. req_stall rises once a point
// waits in the input register while the previous point is still being swept.
// Reset: synchronous, drops all pending points and words; no response
// word appears until a new point is accepted.
module hex27_shape_function_eval_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [h27sf_pkg::COORD_W-1:0]  req_coord_csi,
   input  logic signed [h27sf_pkg::COORD_W-1:0]  req_coord_eta,
   input  logic signed [h27sf_pkg::COORD_W-1:0]  req_coord_zeta,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [h27sf_pkg::NODE_W-1:0]          rsp_node_index,
   output logic signed [h27sf_pkg::SHAPE_W-1:0]  rsp_shape_value,
   output logic signed [h27sf_pkg::DERIV_W-1:0]  rsp_deriv_csi,
   output logic signed [h27sf_pkg::DERIV_W-1:0]  rsp_deriv_eta,
   output logic signed [h27sf_pkg::DERIV_W-1:0]  rsp_deriv_zeta,
   output logic                                  rsp_last_node
);

   localparam int AX = h27sf_pkg::AXES;
   localparam int BW = 2*FRAC_BITS + 4;
   localparam int CW = FRAC_BITS + 2;
   localparam int EW = (CW > h27sf_pkg::COORD_W) ? CW : h27sf_pkg::COORD_W;
   localparam int PIPE_DEPTH = h27sf_pkg::LANE_STAGES + 1;
   localparam logic signed [EW-1:0] ONE_E = EW'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [BW-1:0] ONE_B = BW'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [BW-1:0] ONE_SQ = BW'(1) << (2*FRAC_BITS);

   logic en;
   logic accept, load, issue_last;

   // input register: one point waiting for the sweep
   logic signed [h27sf_pkg::COORD_W-1:0] raw_coord [AX];
   logic signed [EW-1:0] ext_coord [AX];
   logic signed [CW-1:0] coord_in [AX];
   logic signed [CW-1:0] coord_ff [AX];
   logic                 coord_valid_ff, coord_valid_in;

   // per-axis bases and derivatives of the point being swept
   logic signed [2*CW-1:0] sq [AX];
   logic signed [BW-1:0]   xs [AX];
   logic signed [BW-1:0]   basis_in [AX][3];
   logic signed [BW-1:0]   deriv_in [AX][3];
   logic signed [BW-1:0]   basis_ff [AX][3];
   logic signed [BW-1:0]   deriv_ff [AX][3];
   logic                   base_valid_ff, base_valid_in;
   logic [h27sf_pkg::NODE_W-1:0] count_ff, count_in;

   // node select stage
   logic signed [BW-1:0] op_b_in [AX];
   logic signed [BW-1:0] op_d_in [AX];
   logic signed [BW-1:0] op_b_ff [AX];
   logic signed [BW-1:0] op_d_ff [AX];

   logic [PIPE_DEPTH-1:0]  valid_ff;
   h27sf_pkg::meta_type    meta_ff [PIPE_DEPTH];

   // advance everything unless a finished word is held by the receiver
   assign en = !valid_ff[PIPE_DEPTH-1] || !rsp_stall;

   assign issue_last = en && base_valid_ff && (count_ff == h27sf_pkg::LAST_NODE);
   assign load = coord_valid_ff && (!base_valid_ff || issue_last);
   assign req_stall = coord_valid_ff && !load;
   assign accept = req_valid && !req_stall;

   assign raw_coord[0] = req_coord_csi;
   assign raw_coord[1] = req_coord_eta;
   assign raw_coord[2] = req_coord_zeta;

   // clamp to [-1, 1] on the way in
   always_comb begin
      for (int a = 0; a < AX; a++) begin
         ext_coord[a] = EW'(raw_coord[a]);
         if (ext_coord[a] > ONE_E) begin
            coord_in[a] = CW'(ONE_E);
         end else if (ext_coord[a] < -ONE_E) begin
            coord_in[a] = CW'(-ONE_E);
         end else begin
            coord_in[a] = CW'(ext_coord[a]);
         end
      end
   end

   // build bases from one square per axis; everything else is shifts and adds
   always_comb begin
      for (int a = 0; a < AX; a++) begin
         sq[a] = coord_ff[a] * coord_ff[a];
         xs[a] = BW'(coord_ff[a]);
         basis_in[a][0] = sq[a] - (xs[a] <<< FRAC_BITS);
         basis_in[a][1] = (ONE_SQ - sq[a]) <<< 1;
         basis_in[a][2] = sq[a] + (xs[a] <<< FRAC_BITS);
         deriv_in[a][0] = ((xs[a] <<< 1) - ONE_B) <<< FRAC_BITS;
         deriv_in[a][1] = -(xs[a] <<< (FRAC_BITS + 2));
         deriv_in[a][2] = ((xs[a] <<< 1) + ONE_B) <<< FRAC_BITS;
      end
   end

   // sweep control: step through the nodes, refill from the input register
   always_comb begin
      coord_valid_in = accept || (coord_valid_ff && !load);
      if (load) begin
         base_valid_in = 1'b1;
      end else if (issue_last) begin
         base_valid_in = 1'b0;
      end else begin
         base_valid_in = base_valid_ff;
      end
      if (en && base_valid_ff) begin
         count_in = (count_ff == h27sf_pkg::LAST_NODE) ? '0 : count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   // pick each axis's basis and derivative for the current node
   always_comb begin
      for (int a = 0; a < AX; a++) begin
         case (h27sf_pkg::NODE_SEL[count_ff][a])
            2'd0: begin
               op_b_in[a] = basis_ff[a][0];
               op_d_in[a] = deriv_ff[a][0];
            end
            2'd1: begin
               op_b_in[a] = basis_ff[a][1];
               op_d_in[a] = deriv_ff[a][1];
            end
            default: begin
               op_b_in[a] = basis_ff[a][2];
               op_d_in[a] = deriv_ff[a][2];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_valid_ff <= 1'b0;
         base_valid_ff  <= 1'b0;
         count_ff       <= '0;
         valid_ff       <= '0;
      end else begin
         coord_valid_ff <= coord_valid_in;
         base_valid_ff  <= base_valid_in;
         count_ff       <= count_in;
         if (en) begin
            valid_ff <= {valid_ff[PIPE_DEPTH-2:0], base_valid_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         coord_ff <= coord_in;
      end
      if (load) begin
         basis_ff <= basis_in;
         deriv_ff <= deriv_in;
      end
      if (en) begin
         op_b_ff <= op_b_in;
         op_d_ff <= op_d_in;
         meta_ff[0].node <= count_ff;
         meta_ff[0].last <= (count_ff == h27sf_pkg::LAST_NODE);
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            meta_ff[s] <= meta_ff[s-1];
         end
      end
   end

   h27sf_triple_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(h27sf_pkg::SHAPE_W)) u_shape (
      .clock  (clock),
      .en     (en),
      .op_a   (op_b_ff[0]),
      .op_b   (op_b_ff[1]),
      .op_c   (op_b_ff[2]),
      .result (rsp_shape_value)
   );

   h27sf_triple_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(h27sf_pkg::DERIV_W)) u_dcsi (
      .clock  (clock),
      .en     (en),
      .op_a   (op_d_ff[0]),
      .op_b   (op_b_ff[1]),
      .op_c   (op_b_ff[2]),
      .result (rsp_deriv_csi)
   );

   h27sf_triple_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(h27sf_pkg::DERIV_W)) u_deta (
      .clock  (clock),
      .en     (en),
      .op_a   (op_b_ff[0]),
      .op_b   (op_d_ff[1]),
      .op_c   (op_b_ff[2]),
      .result (rsp_deriv_eta)
   );

   h27sf_triple_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(h27sf_pkg::DERIV_W)) u_dzeta (
      .clock  (clock),
      .en     (en),
      .op_a   (op_b_ff[0]),
      .op_b   (op_b_ff[1]),
      .op_c   (op_d_ff[2]),
      .result (rsp_deriv_zeta)
   );

   assign rsp_valid      = valid_ff[PIPE_DEPTH-1];
   assign rsp_node_index = meta_ff[PIPE_DEPTH-1].node;
   assign rsp_last_node  = meta_ff[PIPE_DEPTH-1].last;

   // the closing flag travels only with node 26
   a_last_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_node |-> rsp_node_index == h27sf_pkg::LAST_NODE)
      else $error("last flag on a word other than node 26");

   // an idle sweep sits at node 0
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !base_valid_ff |-> count_ff == '0)
      else $error("node counter off zero with no point loaded");

   // a waiting point starts its sweep at once when the sweep is free
   a_refill: assert property (@(posedge clock) disable iff (reset)
      coord_valid_ff && !base_valid_ff |=> base_valid_ff)
      else $error("waiting point not loaded into an idle sweep");

endmodule

@@ rtl/h27sf_triple_mul.sv @@
`timescale 1ns / 1ps

// Exact signed a*b*c, rounded to nearest (ties away from zero), saturated.
module h27sf_triple_mul #(
   parameter int FRAC_BITS = 16,
   parameter int OUT_W = 18
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [2*FRAC_BITS+3:0] op_a,
   input  logic signed [2*FRAC_BITS+3:0] op_b,
   input  logic signed [2*FRAC_BITS+3:0] op_c,
   output logic signed [OUT_W-1:0]       result
);

   localparam int BW = 2*FRAC_BITS + 4;
   localparam int MW = BW - 1;
   localparam int HW = (MW + 1) / 2;
   localparam int PW = 2*MW;
   localparam int QW = (PW + 3) / 4;
   localparam int SW = 4*QW + MW;
   localparam int K = 5*FRAC_BITS + 3;
   localparam int RW = SW - K;
   localparam int TW = ((RW > OUT_W) ? RW : OUT_W) + 1;
   localparam logic [TW-1:0] LIM_POS = (TW'(1) << (OUT_W-1)) - TW'(1);
   localparam logic [TW-1:0] LIM_NEG = TW'(1) << (OUT_W-1);

   logic [BW-1:0] neg_a, neg_b, neg_c;
   logic [MW-1:0] mag_a, mag_b, mag_c;

   logic [MW+HW-1:0]      pp0_in, pp0_ff;
   logic [2*MW-HW-1:0]    pp1_in, pp1_ff;
   logic [MW-1:0]         magc_a_ff, magc_b_ff;
   logic                  sign_a_ff, sign_b_ff, sign_c_ff, sign_d_ff;
   logic [PW-1:0]         p1_in, p1_ff;
   logic [4*QW-1:0]       p1x;
   logic [QW+MW-1:0]      cp_in [4];
   logic [QW+MW-1:0]      cp_ff [4];
   logic [SW-1:0]         sum_in, sum_ff;
   logic [SW-1:0]         rnd;
   logic [TW-1:0]         q;
   logic [TW-1:0]         res_t;
   logic signed [OUT_W-1:0] res_in, res_ff;

   // stage A: magnitudes, first product split over the low and high half of b
   always_comb begin
      neg_a = -op_a;
      neg_b = -op_b;
      neg_c = -op_c;
      mag_a = op_a[BW-1] ? neg_a[MW-1:0] : op_a[MW-1:0];
      mag_b = op_b[BW-1] ? neg_b[MW-1:0] : op_b[MW-1:0];
      mag_c = op_c[BW-1] ? neg_c[MW-1:0] : op_c[MW-1:0];
      pp0_in = mag_a * mag_b[HW-1:0];
      pp1_in = mag_a * mag_b[MW-1:HW];
   end

   // stage B: merge the halves
   assign p1_in = PW'(pp0_ff) + (PW'(pp1_ff) << HW);

   // stage C: second product in four chunks
   assign p1x = (4*QW)'(p1_ff);
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cp_in[i] = p1x[i*QW +: QW] * magc_b_ff;
      end
   end

   // stage D: add the chunks
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 4; i++) begin
         sum_in = sum_in + (SW'(cp_ff[i]) << (i*QW));
      end
   end

   // stage E: round, sign, saturate
   always_comb begin
      rnd = sum_ff + (SW'(1) << (K-1));
      q = TW'(rnd[SW-1:K]);
      if (!sign_d_ff) begin
         res_t = (q > LIM_POS) ? LIM_POS : q;
      end else begin
         res_t = (q > LIM_NEG) ? -LIM_NEG : -q;
      end
      res_in = res_t[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff    <= pp0_in;
         pp1_ff    <= pp1_in;
         magc_a_ff <= mag_c;
         sign_a_ff <= op_a[BW-1] ^ op_b[BW-1] ^ op_c[BW-1];
         p1_ff     <= p1_in;
         magc_b_ff <= magc_a_ff;
         sign_b_ff <= sign_a_ff;
         cp_ff     <= cp_in;
         sign_c_ff <= sign_b_ff;
         sum_ff    <= sum_in;
         sign_d_ff <= sign_c_ff;
         res_ff    <= res_in;
      end
   end

   assign result = res_ff;

endmodule

@@ tb/hex27_shape_function_eval_checker.sv @@
`timescale 1ns / 1ps

module hex27_shape_function_eval_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic signed [h27sf_pkg::COORD_W-1:0] req_coord_csi,
   input  logic signed [h27sf_pkg::COORD_W-1:0] req_coord_eta,
   input  logic signed [h27sf_pkg::COORD_W-1:0] req_coord_zeta,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [h27sf_pkg::NODE_W-1:0] rsp_node_index,
   input  logic signed [h27sf_pkg::SHAPE_W-1:0] rsp_shape_value,
   input  logic signed [h27sf_pkg::DERIV_W-1:0] rsp_deriv_csi,
   input  logic signed [h27sf_pkg::DERIV_W-1:0] rsp_deriv_eta,
   input  logic signed [h27sf_pkg::DERIV_W-1:0] rsp_deriv_zeta,
   input  logic rsp_last_node,
   output int   mismatch_count,
   output int   words_pending
);

   localparam int FRAC = 16;
   localparam longint ONE = 64'sd1 <<< FRAC;
   localparam int NW = h27sf_pkg::NODE_W;
   localparam int SHW = h27sf_pkg::SHAPE_W;
   localparam int DW = h27sf_pkg::DERIV_W;
   localparam int CRW = h27sf_pkg::COORD_W;

   typedef struct {
      logic [NW-1:0]         node;
      logic signed [SHW-1:0] shape;
      logic signed [DW-1:0]  dc;
      logic signed [DW-1:0]  de;
      logic signed [DW-1:0]  dz;
      logic                  last;
   } node_word_type;

   node_word_type node_words_due[$];

   initial mismatch_count = 0;

   function automatic longint clamp_coord(logic signed [CRW-1:0] raw);
      longint v;
      v = raw;
      if (v > ONE) v = ONE;
      if (v < -ONE) v = -ONE;
      return v;
   endfunction

   // exact product of three terms (2F+1 fraction bits each), round half away
   function automatic longint round_triple(longint a, longint b, longint c);
      logic [127:0] mag;
      logic [63:0]  q;
      bit           neg;
      neg = (a < 0) ^ (b < 0) ^ (c < 0);
      mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
      mag = mag * 128'(c < 0 ? -c : c);
      mag = mag + (128'd1 << (5 * FRAC + 2));
      q = 64'(mag >> (5 * FRAC + 3)) & ((64'd1 << 40) - 1);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint saturate(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -(64'sd1 <<< (w - 1));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   // per axis: three bases then three derivatives
   task automatic predict_point(logic signed [CRW-1:0] c0,
                                logic signed [CRW-1:0] c1,
                                logic signed [CRW-1:0] c2);
      longint basis [h27sf_pkg::AXES][6];
      longint x, p, dc, de, dz;
      node_word_type w;
      int si, sj, sk;
      for (int a = 0; a < h27sf_pkg::AXES; a++) begin
         x = clamp_coord(a == 0 ? c0 : (a == 1 ? c1 : c2));
         basis[a][0] = x * (x - ONE);
         basis[a][1] = 2 * (ONE * ONE - x * x);
         basis[a][2] = x * (x + ONE);
         basis[a][3] = (2 * x - ONE) * ONE;
         basis[a][4] = -4 * x * ONE;
         basis[a][5] = (2 * x + ONE) * ONE;
      end
      for (int n = 0; n < h27sf_pkg::NODE_COUNT; n++) begin
         si = h27sf_pkg::NODE_SEL[n][0];
         sj = h27sf_pkg::NODE_SEL[n][1];
         sk = h27sf_pkg::NODE_SEL[n][2];
         p  = round_triple(basis[0][si], basis[1][sj], basis[2][sk]);
         dc = round_triple(basis[0][3+si], basis[1][sj], basis[2][sk]);
         de = round_triple(basis[0][si], basis[1][3+sj], basis[2][sk]);
         dz = round_triple(basis[0][si], basis[1][sj], basis[2][3+sk]);
         w.node  = NW'(n);
         w.shape = SHW'(saturate(p, SHW));
         w.dc    = DW'(saturate(dc, DW));
         w.de    = DW'(saturate(de, DW));
         w.dz    = DW'(saturate(dz, DW));
         w.last  = (n == h27sf_pkg::NODE_COUNT - 1);
         node_words_due.push_back(w);
      end
   endtask

   task automatic report(string field, longint got, longint want);
      $display("%0t: %s differs: got %0d, want %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      node_word_type w;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_point(req_coord_csi, req_coord_eta, req_coord_zeta);
         if (rsp_valid && !rsp_stall) begin
            if (node_words_due.size() == 0) begin
               report("unexpected word, node", rsp_node_index, -1);
            end else begin
               w = node_words_due.pop_front();
               if (rsp_node_index !== w.node) report("node_index", rsp_node_index, w.node);
               if (rsp_shape_value !== w.shape) report("shape_value", rsp_shape_value, w.shape);
               if (rsp_deriv_csi !== w.dc) report("deriv_csi", rsp_deriv_csi, w.dc);
               if (rsp_deriv_eta !== w.de) report("deriv_eta", rsp_deriv_eta, w.de);
               if (rsp_deriv_zeta !== w.dz) report("deriv_zeta", rsp_deriv_zeta, w.dz);
               if (rsp_last_node !== w.last) report("last_node", rsp_last_node, w.last);
            end
         end
      end
      words_pending = node_words_due.size();
   end

endmodule

@@ tb/tb_hex27_shape_function_eval_core.sv @@
`timescale 1ns / 1ps

module tb_hex27_shape_function_eval_core;

   localparam int CRW = h27sf_pkg::COORD_W;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [CRW-1:0]                req_coord_csi = '0;
   logic signed [CRW-1:0]                req_coord_eta = '0;
   logic signed [CRW-1:0]                req_coord_zeta = '0;

   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [h27sf_pkg::NODE_W-1:0]         rsp_node_index;
   logic signed [h27sf_pkg::SHAPE_W-1:0] rsp_shape_value;
   logic signed [h27sf_pkg::DERIV_W-1:0] rsp_deriv_csi;
   logic signed [h27sf_pkg::DERIV_W-1:0] rsp_deriv_eta;
   logic signed [h27sf_pkg::DERIV_W-1:0] rsp_deriv_zeta;
   logic                                 rsp_last_node;

   int mismatch_count;
   int words_pending;

   // idle odds in percent for each side, changed per phase
   int send_gap_pct  = 0;
   int recv_stall_pct = 0;
   // bump hold_request to start one long receiver hold-off
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hex27_shape_function_eval_core u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_coord_csi, .req_coord_eta, .req_coord_zeta,
      .rsp_valid, .rsp_stall, .rsp_node_index, .rsp_shape_value,
      .rsp_deriv_csi, .rsp_deriv_eta, .rsp_deriv_zeta, .rsp_last_node
   );

   hex27_shape_function_eval_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_coord_csi, .req_coord_eta, .req_coord_zeta,
      .rsp_valid, .rsp_stall, .rsp_node_index, .rsp_shape_value,
      .rsp_deriv_csi, .rsp_deriv_eta, .rsp_deriv_zeta, .rsp_last_node,
      .mismatch_count, .words_pending
   );

   // Receiver: a requested hold-off keeps stall high for a long stretch while
   // the sender keeps offering points; otherwise stall at the phase's odds.
   always @(posedge clock) begin
      if (hold_seen != hold_request) begin
         hold_seen <= hold_request;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Offer one point; hold it until the block takes it. Valid stays high
   // into the next word unless a gap is drawn.
   task automatic send_point(logic signed [CRW-1:0] c0,
                             logic signed [CRW-1:0] c1,
                             logic signed [CRW-1:0] c2);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_coord_csi  <= c0;
      req_coord_eta  <= c1;
      req_coord_zeta <= c2;
      do @(posedge clock); while (req_stall);
   endtask

   // Draw a coordinate: mostly in range, some special points, some raw
   // 18-bit noise that exercises the clamp and every bit.
   function automatic logic signed [CRW-1:0] pick_coord();
      int r;
      r = $urandom_range(99);
      if (r < 70) return CRW'(int'($urandom_range(131072)) - 65536);
      if (r < 85) begin
         case ($urandom_range(5))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'sd32768;
            3: return -18'sd32768;
            4: return 18'sd0;
            default: return CRW'($urandom_range(1)) ? 18'sd1 : -18'sd1;
         endcase
      end
      return CRW'($urandom);
   endfunction

   initial begin
      logic signed [CRW-1:0] edge_vals [12];
      edge_vals = '{18'sd65536, -18'sd65536, 18'sd0, 18'sd32768, -18'sd32768,
                    18'sd65537, -18'sd65537, 18'sd131071, -18'sd131072,
                    18'sd1, -18'sd1, 18'sd21845};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, clamp, mid-points, near-zero and the ±0.5 ties
      for (int i = 0; i < 12; i++)
         send_point(edge_vals[i], edge_vals[(i + 4) % 12], edge_vals[(i + 7) % 12]);
      send_point(18'sd65536, 18'sd65536, 18'sd65536);
      send_point(-18'sd65536, -18'sd65536, -18'sd65536);
      send_point(18'sd0, 18'sd0, 18'sd0);
      send_point(18'sd131071, -18'sd131072, 18'sd65535);
      send_point(18'sd32767, -18'sd32769, 18'sd3);

      // random phases: free run, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         send_gap_pct   = (ph == 1) ? 58 : (ph == 3) ? 11 : 0;
         recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 11 : 0;
         for (int k = 0; k < 85; k++) begin
            if (ph == 0 && k == 10) hold_request++;
            send_point(pick_coord(), pick_coord(), pick_coord());
         end
      end
      req_valid <= 1'b0;

      // let the checker log the last point, drain, then let the pipeline settle
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/h27sf_pkg.sv
rtl/h27sf_triple_mul.sv
rtl/hex27_shape_function_eval_core.sv
tb/hex27_shape_function_eval_checker.sv
tb/tb_hex27_shape_function_eval_core.sv
